FILE: hw/rtl/sumd_frame_decoder_macros.svh
// assertion macros shared by the frame decoder modules
// no dependencies; included by the modules that check their own logic
`ifndef SUMD_FRAME_DECODER_MACROS_SVH
`define SUMD_FRAME_DECODER_MACROS_SVH

// condition implies consequence in the same cycle
`define SUMD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sumd assertion failed");

// condition implies consequence in the following cycle
`define SUMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sumd assertion failed");

`endif

FILE: hw/rtl/sumd_pkg.sv
// shared types, constants and the crc step for the frame decoder
// no dependencies; used by every module of the block
package sumd_pkg;

    localparam int MAX_CHANNELS_DEFAULT = 16;
    localparam int DESC_DEPTH           = 2;

    localparam logic [7:0]  START_BYTE      = 8'hA8;
    localparam logic [7:0]  STATUS_LIVE     = 8'h01;
    localparam logic [7:0]  STATUS_FAILSAFE = 8'h81;
    localparam logic [7:0]  COUNT_MIN       = 8'd2;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [15:0] CRC_TOP         = 16'h8000;

    typedef enum logic [3:0] {
        PH_HUNT   = 4'b0001,
        PH_START  = 4'b0010,
        PH_STATUS = 4'b0100,
        PH_DATA   = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        EM_IDLE = 3'b001,
        EM_READ = 3'b010,
        EM_SHOW = 3'b100
    } emit_state_t;

    // one finished frame handed from parser to emitter
    typedef struct packed {
        logic [5:0] count;
        logic       crc_ok;
    } frame_desc_t;

    function automatic logic [15:0] crc_add(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
                c = (c << 1) ^ CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/sumd_if.sv
// valid/ready channel interfaces for serial bytes in and channel results out
// depends on nothing
interface sumd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sumd_chan_if;
    logic        valid;
    logic        ready;
    logic [4:0]  channel_index;
    logic [15:0] channel_value;
    logic [5:0]  channel_count;
    logic        crc_ok;
    logic        last;

    modport source (output valid, output channel_index, output channel_value,
                    output channel_count, output crc_ok, output last, input ready);
    modport sink   (input valid, input channel_index, input channel_value,
                    input channel_count, input crc_ok, input last, output ready);
endinterface

FILE: hw/rtl/sumd_parser.sv
// front end: byte parser, running crc and channel store writes
// depends on sumd_pkg and sumd_byte_if
module sumd_parser #(
    parameter int MAX_CHANNELS = sumd_pkg::MAX_CHANNELS_DEFAULT,
    parameter int AW           = $clog2(MAX_CHANNELS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    sumd_byte_if.sink             rx,
    input  logic                  desc_empty,
    input  logic                  back_busy,
    output logic                  desc_push,
    output sumd_pkg::frame_desc_t desc,
    output logic                  wr_en,
    output logic [AW-1:0]         wr_addr,
    output logic [15:0]           wr_data
);

    sumd_pkg::phase_t phase_reg, phase_next;
    logic [6:0]  byte_index_reg, byte_index_next;
    logic [5:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  hold_reg, hold_next;
    logic [7:0]  rcv_hi_reg, rcv_hi_next;

    logic        accept;
    logic [7:0]  b;
    logic [6:0]  nbytes;
    logic [15:0] crc_step;

    // data bytes wait until the emitter has drained the shared store
    assign rx.ready = (phase_reg != sumd_pkg::PH_DATA) || (desc_empty && !back_busy);
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.rx_byte;
    assign nbytes   = {count_reg, 1'b0};
    assign crc_step = sumd_pkg::crc_add(crc_reg, b);

    assign wr_addr     = byte_index_reg[AW:1];
    assign wr_data     = {hold_reg, b};
    assign desc.count  = count_reg;
    assign desc.crc_ok = (crc_reg == {rcv_hi_reg, b});

    always_comb
    begin
        phase_next      = phase_reg;
        byte_index_next = byte_index_reg;
        count_next      = count_reg;
        crc_next        = crc_reg;
        hold_next       = hold_reg;
        rcv_hi_next     = rcv_hi_reg;
        wr_en           = 1'b0;
        desc_push       = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                sumd_pkg::PH_HUNT:
                begin
                    byte_index_next = 7'd0;
                    if (b == sumd_pkg::START_BYTE)
                    begin
                        count_next = 6'd0;
                        crc_next   = sumd_pkg::crc_add(16'h0000, b);
                        phase_next = sumd_pkg::PH_START;
                    end
                end
                sumd_pkg::PH_START:
                begin
                    if (b == sumd_pkg::STATUS_LIVE || b == sumd_pkg::STATUS_FAILSAFE)
                    begin
                        crc_next   = crc_step;
                        phase_next = sumd_pkg::PH_STATUS;
                    end
                    else
                        phase_next = sumd_pkg::PH_HUNT;
                end
                sumd_pkg::PH_STATUS:
                begin
                    if (b >= sumd_pkg::COUNT_MIN && b <= 8'(MAX_CHANNELS))
                    begin
                        crc_next        = crc_step;
                        count_next      = b[5:0];
                        byte_index_next = 7'd0;
                        phase_next      = sumd_pkg::PH_DATA;
                    end
                    else
                        phase_next = sumd_pkg::PH_HUNT;
                end
                sumd_pkg::PH_DATA:
                begin
                    if (byte_index_reg < nbytes)
                    begin
                        crc_next = crc_step;
                        if (!byte_index_reg[0])
                            hold_next = b;
                        else
                            wr_en = 1'b1;
                        byte_index_next = byte_index_reg + 7'd1;
                    end
                    else if (byte_index_reg == nbytes)
                    begin
                        rcv_hi_next     = b;
                        byte_index_next = byte_index_reg + 7'd1;
                    end
                    else
                    begin
                        desc_push       = 1'b1;
                        byte_index_next = 7'd0;
                        phase_next      = sumd_pkg::PH_HUNT;
                    end
                end
                default:
                    phase_next = sumd_pkg::PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= sumd_pkg::PH_HUNT;
            byte_index_reg <= 7'd0;
            count_reg      <= 6'd0;
            crc_reg        <= 16'h0000;
            hold_reg       <= 8'h00;
            rcv_hi_reg     <= 8'h00;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_index_reg <= byte_index_next;
            count_reg      <= count_next;
            crc_reg        <= crc_next;
            hold_reg       <= hold_next;
            rcv_hi_reg     <= rcv_hi_next;
        end
    end

endmodule

FILE: hw/rtl/sumd_desc_fifo.sv
// small queue of finished-frame descriptors between parser and emitter
// depends on sumd_pkg and the assertion macro header
`include "sumd_frame_decoder_macros.svh"

module sumd_desc_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sumd_pkg::frame_desc_t push_data,
    input  logic                  pop,
    output sumd_pkg::frame_desc_t pop_data,
    output logic                  empty,
    output logic                  full
);

    localparam int PW = $clog2(sumd_pkg::DESC_DEPTH);
    localparam int CW = $clog2(sumd_pkg::DESC_DEPTH + 1);

    sumd_pkg::frame_desc_t entry_reg [sumd_pkg::DESC_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;

    assign empty    = (fill_reg == CW'(0));
    assign full     = (fill_reg == CW'(sumd_pkg::DESC_DEPTH));
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(sumd_pkg::DESC_DEPTH - 1)) ? PW'(0)
                                                                       : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(sumd_pkg::DESC_DEPTH - 1)) ? PW'(0)
                                                                       : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
            fill_next = fill_reg + CW'(1);
        else if (pop && !push)
            fill_next = fill_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    `SUMD_ASSERT_NOW(a_no_push_full, clk, rst_n, push, !full)
    `SUMD_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, !empty)
    `SUMD_ASSERT_NEXT(a_push_not_empty, clk, rst_n, push && !pop, !empty)

endmodule

FILE: hw/rtl/sumd_emitter.sv
// back end: channel store memory and per-channel result sequencer
// depends on sumd_pkg, sumd_chan_if and the assertion macro header
`include "sumd_frame_decoder_macros.svh"

module sumd_emitter #(
    parameter int MAX_CHANNELS = sumd_pkg::MAX_CHANNELS_DEFAULT,
    parameter int AW           = $clog2(MAX_CHANNELS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [15:0]           wr_data,
    input  logic                  desc_empty,
    input  sumd_pkg::frame_desc_t desc,
    output logic                  desc_pop,
    output logic                  busy,
    sumd_chan_if.source           result
);

    logic [15:0] store_mem [MAX_CHANNELS];
    logic [15:0] rd_data_reg;

    sumd_pkg::emit_state_t state_reg, state_next;
    logic [AW-1:0] k_reg, k_next;
    logic [5:0]    count_reg, count_next;
    logic          ok_reg, ok_next;
    logic          is_last;

    assign is_last = (6'(k_reg) + 6'd1 == count_reg);
    assign busy    = (state_reg != sumd_pkg::EM_IDLE);

    assign result.valid         = (state_reg == sumd_pkg::EM_SHOW);
    assign result.channel_index = 5'(k_reg);
    assign result.channel_value = rd_data_reg;
    assign result.channel_count = count_reg;
    assign result.crc_ok        = ok_reg;
    assign result.last          = is_last;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        count_next = count_reg;
        ok_next    = ok_reg;
        desc_pop   = 1'b0;
        unique case (state_reg)
            sumd_pkg::EM_IDLE:
            begin
                if (!desc_empty)
                begin
                    desc_pop   = 1'b1;
                    k_next     = '0;
                    count_next = desc.count;
                    ok_next    = desc.crc_ok;
                    state_next = sumd_pkg::EM_READ;
                end
            end
            sumd_pkg::EM_READ:
                state_next = sumd_pkg::EM_SHOW;
            sumd_pkg::EM_SHOW:
            begin
                if (result.ready)
                begin
                    if (is_last)
                        state_next = sumd_pkg::EM_IDLE;
                    else
                    begin
                        k_next     = k_reg + AW'(1);
                        state_next = sumd_pkg::EM_READ;
                    end
                end
            end
            default:
                state_next = sumd_pkg::EM_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sumd_pkg::EM_IDLE;
            k_reg     <= '0;
            count_reg <= 6'd0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            count_reg <= count_next;
            ok_reg    <= ok_next;
        end
    end

    // single write port, one registered read port at the current channel
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= wr_data;
        rd_data_reg <= store_mem[k_reg];
    end

    `SUMD_ASSERT_NOW(a_write_only_idle, clk, rst_n, wr_en, state_reg == sumd_pkg::EM_IDLE)
    `SUMD_ASSERT_NOW(a_index_in_frame, clk, rst_n, result.valid, 6'(k_reg) < count_reg)
    `SUMD_ASSERT_NEXT(a_last_ends_frame, clk, rst_n,
        result.valid && result.ready && is_last, state_reg == sumd_pkg::EM_IDLE)

endmodule

FILE: hw/rtl/sumd_frame_decoder.sv
// radio-control frame decoder: bytes in, one result per channel out
// depends on sumd_pkg, sumd_if, sumd_parser, sumd_desc_fifo, sumd_emitter
//
// usage:
//   rx carries one received serial byte per request (valid/ready).
//   result carries one request per channel of a frame: index, raw value,
//   channel count, crc verdict and a last flag on the final channel.
//   results of a frame appear only after its second crc byte is taken,
//   even when the crc check fails (crc_ok low).
// timing:
//   header and hunting bytes are taken one per cycle. the first result of
//   a frame becomes valid once its descriptor has passed through the queue
//   and the emitter's read state; each further result, once the previous
//   one is taken, again passes the read state for the registered store read.
//   data bytes of the next frame wait until the previous frame's results
//   have all been taken, since both use the one channel store.
// reset: rst_n clears the parser to hunting and empties the result queue;
//   the channel store holds no reset value and is always written first.
// stalls: a low result.ready holds the current result stable.
module sumd_frame_decoder #(
    parameter int MAX_CHANNELS = sumd_pkg::MAX_CHANNELS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    sumd_byte_if.sink   rx,
    sumd_chan_if.source result
);

    localparam int AW = $clog2(MAX_CHANNELS);

    logic                  desc_push;
    logic                  desc_pop;
    logic                  desc_empty;
    logic                  desc_full;
    logic                  back_busy;
    sumd_pkg::frame_desc_t push_desc;
    sumd_pkg::frame_desc_t pop_desc;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [15:0]           wr_data;

    sumd_parser #(
        .MAX_CHANNELS(MAX_CHANNELS),
        .AW(AW)
    ) u_parser (
        .clk(clk),
        .rst_n(rst_n),
        .rx(rx),
        .desc_empty(desc_empty),
        .back_busy(back_busy || desc_full),
        .desc_push(desc_push),
        .desc(push_desc),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data)
    );

    sumd_desc_fifo u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(desc_push),
        .push_data(push_desc),
        .pop(desc_pop),
        .pop_data(pop_desc),
        .empty(desc_empty),
        .full(desc_full)
    );

    sumd_emitter #(
        .MAX_CHANNELS(MAX_CHANNELS),
        .AW(AW)
    ) u_emitter (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .desc_empty(desc_empty),
        .desc(pop_desc),
        .desc_pop(desc_pop),
        .busy(back_busy),
        .result(result)
    );

endmodule

FILE: verif/sumd_frame_decoder_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for sumd_frame_decoder: serial bytes in, channel results out
// depends on sumd_pkg and the sumd_byte_if / sumd_chan_if interfaces of the rtl
module sumd_frame_decoder_tb;

    localparam int MAX_CH       = 16;
    localparam int ITEM_TARGET  = 280;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_NS     = 2_000_000;

    typedef struct packed {
        logic [4:0]  index;
        logic [15:0] value;
        logic [5:0]  count;
        logic        crc_ok;
        logic        last;
    } chan_result_t;

    // one directed frame: leading byte, header, alternating channel fill, crc choice
    typedef struct packed {
        logic [7:0]  noise;
        logic [7:0]  status;
        logic [7:0]  count;
        logic [15:0] even_val;
        logic [15:0] odd_val;
        logic        crc_good;
        logic        typed;
    } frame_row_t;

    logic clk;
    logic rst_n;

    sumd_byte_if rx_bus();
    sumd_chan_if chan_bus();

    sumd_frame_decoder #(
        .MAX_CHANNELS (MAX_CH)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_bus),
        .result (chan_bus)
    );

    // frame tracker state
    sumd_pkg::phase_t track_phase;
    logic [6:0]  data_pos;
    logic [5:0]  frame_chans;
    logic [15:0] crc_acc;
    logic [7:0]  high_hold;
    logic [15:0] chan_vals [MAX_CH];
    logic [15:0] crc_seen;

    chan_result_t pending_channels[$];
    logic [7:0]   frame_bytes[$];
    logic [15:0]  frame_vals [MAX_CH];

    int error_count;
    int results_seen;
    int frames_decoded;
    int bytes_sent;
    int items_counted;
    int rx_idle_pct;
    int res_idle_pct;
    int holds_asked;
    int holds_done;
    int hold_left;

    frame_row_t directed_rows [12] = '{
        '{8'h00, sumd_pkg::STATUS_LIVE,     8'd2,  16'h0000, 16'hFFFF, 1'b1, 1'b1},
        '{8'hFF, sumd_pkg::STATUS_FAILSAFE, 8'd16, 16'hFFFF, 16'h0000, 1'b1, 1'b1},
        '{8'h55, sumd_pkg::STATUS_LIVE,     8'd3,  16'h1234, 16'hABCD, 1'b0, 1'b1},
        // start byte in the status slot is dropped, not taken as a new start
        '{8'h00, sumd_pkg::START_BYTE,      8'd2,  16'h0000, 16'h0000, 1'b1, 1'b1},
        '{8'h00, sumd_pkg::STATUS_LIVE,     8'd1,  16'h0000, 16'h0000, 1'b1, 1'b1},
        '{8'h7F, sumd_pkg::STATUS_FAILSAFE, 8'd17, 16'h0000, 16'h0000, 1'b1, 1'b1},
        '{8'h80, sumd_pkg::STATUS_LIVE,     8'd0,  16'h0000, 16'h0000, 1'b1, 1'b1},
        '{8'h00, sumd_pkg::STATUS_LIVE,     8'hFF, 16'h0000, 16'h0000, 1'b1, 1'b1},
        '{8'h00, sumd_pkg::STATUS_FAILSAFE, 8'd4,  16'hA8A8, 16'h00A8, 1'b1, 1'b1},
        '{sumd_pkg::START_BYTE, sumd_pkg::STATUS_LIVE, 8'd2, 16'h1111, 16'h2222, 1'b1, 1'b0},
        '{8'h00, sumd_pkg::STATUS_FAILSAFE, 8'd2,  16'h8000, 16'h7FFF, 1'b0, 1'b0},
        '{8'h01, sumd_pkg::STATUS_LIVE,     8'd5,  16'h5AA5, 16'hA55A, 1'b1, 1'b0}
    };

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // crc-16 0x1021, one input bit at a time, msb first
    function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = acc[15] ^ b[i];
            acc = {acc[14:0], 1'b0};
            if (fb)
                acc = acc ^ sumd_pkg::CRC_POLY;
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    // advances the frame tracker by one accepted byte
    task automatic track_byte(input logic [7:0] b, input bit publish, output bit ignored);
        chan_result_t r;
        int nbytes;
        ignored = 1'b0;
        case (track_phase)
            sumd_pkg::PH_HUNT:
            begin
                data_pos = '0;
                if (b == sumd_pkg::START_BYTE)
                begin
                    frame_chans = '0;
                    crc_acc     = crc16_step(16'h0000, b);
                    track_phase = sumd_pkg::PH_START;
                end
                else
                    ignored = 1'b1;
            end
            sumd_pkg::PH_START:
            begin
                if (b == sumd_pkg::STATUS_LIVE || b == sumd_pkg::STATUS_FAILSAFE)
                begin
                    crc_acc     = crc16_step(crc_acc, b);
                    track_phase = sumd_pkg::PH_STATUS;
                end
                else
                    track_phase = sumd_pkg::PH_HUNT;
            end
            sumd_pkg::PH_STATUS:
            begin
                if (b >= sumd_pkg::COUNT_MIN && b <= MAX_CH)
                begin
                    crc_acc     = crc16_step(crc_acc, b);
                    frame_chans = b[5:0];
                    data_pos    = '0;
                    track_phase = sumd_pkg::PH_DATA;
                end
                else
                    track_phase = sumd_pkg::PH_HUNT;
            end
            default:
            begin
                nbytes = 2 * frame_chans;
                if (data_pos < nbytes)
                begin
                    crc_acc = crc16_step(crc_acc, b);
                    if (!data_pos[0])
                        high_hold = b;
                    else
                        chan_vals[data_pos >> 1] = {high_hold, b};
                    data_pos++;
                end
                else if (data_pos == nbytes)
                begin
                    crc_seen = {b, 8'h00};
                    data_pos++;
                end
                else
                begin
                    crc_seen[7:0] = b;
                    frames_decoded++;
                    for (int k = 0; k < frame_chans; k++)
                    begin
                        r.index  = 5'(k);
                        r.value  = chan_vals[k];
                        r.count  = frame_chans;
                        r.crc_ok = (crc_acc == crc_seen);
                        r.last   = (k == frame_chans - 1);
                        if (publish)
                            pending_channels.push_back(r);
                    end
                    track_phase = sumd_pkg::PH_HUNT;
                    data_pos    = '0;
                end
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input bit publish);
        bit ignored;
        @(negedge clk);
        while ($urandom_range(99) < rx_idle_pct)
        begin
            rx_bus.valid <= 1'b0;
            @(negedge clk);
        end
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= b;
        do
            @(posedge clk);
        while (rx_bus.ready !== 1'b1);
        bytes_sent++;
        track_byte(b, publish, ignored);
        if (!ignored)
            items_counted++;
    endtask

    task automatic rx_quiet();
        @(negedge clk);
        rx_bus.valid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        while (pending_channels.size() != 0)
            @(posedge clk);
    endtask

    // appends a frame built from frame_vals; header only when full is clear
    task automatic build_frame(input logic [7:0] status, input logic [7:0] count,
                               input bit crc_good, input bit full);
        logic [15:0] crc;
        frame_bytes.push_back(sumd_pkg::START_BYTE);
        frame_bytes.push_back(status);
        frame_bytes.push_back(count);
        if (!full)
            return;
        crc = crc16_step(crc16_step(crc16_step(16'h0000, sumd_pkg::START_BYTE), status),
                         count);
        for (int k = 0; k < count; k++)
        begin
            frame_bytes.push_back(frame_vals[k][15:8]);
            frame_bytes.push_back(frame_vals[k][7:0]);
            crc = crc16_step(crc16_step(crc, frame_vals[k][15:8]), frame_vals[k][7:0]);
        end
        if (!crc_good)
            crc = ~crc;
        frame_bytes.push_back(crc[15:8]);
        frame_bytes.push_back(crc[7:0]);
    endtask

    // mostly well-formed frames with random content, some stray bytes,
    // broken headers and cut-off frames
    task automatic random_chunk();
        int roll;
        int n;
        int cut;
        logic [7:0] status;
        roll = $urandom_range(99);
        frame_bytes.delete();
        if (roll < 10)
            frame_bytes.push_back(8'($urandom_range(255)));
        if (roll >= 10 && roll < 18)
        begin
            status = ($urandom_range(1) == 0) ? 8'($urandom_range(255))
                                              : sumd_pkg::STATUS_LIVE;
            build_frame(status, 8'($urandom_range(40)), 1'b1, 1'b0);
        end
        else
        begin
            n = $urandom_range(99);
            if (n < 70)
                n = $urandom_range(4, 2);
            else if (n < 92)
                n = $urandom_range(15, 5);
            else
                n = MAX_CH;
            for (int k = 0; k < n; k++)
                frame_vals[k] = ($urandom_range(99) < 5) ? 16'hA8A8 : 16'($urandom_range(65535));
            status = ($urandom_range(1) == 0) ? sumd_pkg::STATUS_LIVE
                                              : sumd_pkg::STATUS_FAILSAFE;
            build_frame(status, 8'(n), $urandom_range(99) < 80, 1'b1);
            if ($urandom_range(99) < 5)
            begin
                cut = $urandom_range(frame_bytes.size() - 1, 1);
                while (frame_bytes.size() > cut)
                    void'(frame_bytes.pop_back());
            end
        end
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], 1'b1);
    endtask

    // result side: random stalls plus an occasional long hold-off
    initial
    begin
        chan_bus.ready = 1'b0;
        hold_left      = 0;
        holds_done     = 0;
        forever
        begin
            @(negedge clk);
            if (holds_done < holds_asked)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                chan_bus.ready <= 1'b0;
            end
            else
                chan_bus.ready <= ($urandom_range(99) >= res_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        chan_result_t want;
        if (rst_n && chan_bus.valid === 1'b1 && chan_bus.ready === 1'b1)
        begin
            results_seen++;
            if (pending_channels.size() == 0)
                report_mismatch("channel result with none pending", chan_bus.channel_value, 0);
            else
            begin
                want = pending_channels.pop_front();
                if (chan_bus.channel_index !== want.index)
                    report_mismatch("channel_index", chan_bus.channel_index, want.index);
                if (chan_bus.channel_value !== want.value)
                    report_mismatch("channel_value", chan_bus.channel_value, want.value);
                if (chan_bus.channel_count !== want.count)
                    report_mismatch("channel_count", chan_bus.channel_count, want.count);
                if (chan_bus.crc_ok !== want.crc_ok)
                    report_mismatch("crc_ok", chan_bus.crc_ok, want.crc_ok);
                if (chan_bus.last !== want.last)
                    report_mismatch("last", chan_bus.last, want.last);
            end
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("timeout with %0d channel results still pending", pending_channels.size());
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        frame_row_t row;
        chan_result_t r;
        bit full;
        int goal;
        int base;

        rx_bus.valid   = 1'b0;
        rx_bus.rx_byte = 8'h00;
        rst_n          = 1'b0;
        error_count    = 0;
        results_seen   = 0;
        frames_decoded = 0;
        bytes_sent     = 0;
        items_counted  = 0;
        holds_asked    = 0;
        rx_idle_pct    = 15;
        res_idle_pct   = 70;
        track_phase    = sumd_pkg::PH_HUNT;
        data_pos       = '0;
        frame_chans    = '0;
        crc_acc        = '0;
        high_hold      = '0;
        crc_seen       = '0;
        foreach (chan_vals[k])
            chan_vals[k] = '0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed frames; typed rows carry their own expected results
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            frame_bytes.delete();
            frame_bytes.push_back(row.noise);
            for (int k = 0; k < MAX_CH; k++)
                frame_vals[k] = k[0] ? row.odd_val : row.even_val;
            full = (row.status == sumd_pkg::STATUS_LIVE ||
                    row.status == sumd_pkg::STATUS_FAILSAFE) &&
                   row.count >= sumd_pkg::COUNT_MIN && row.count <= MAX_CH;
            build_frame(row.status, row.count, row.crc_good, full);
            foreach (frame_bytes[j])
                send_byte(frame_bytes[j], !row.typed);
            if (row.typed && full)
            begin
                for (int k = 0; k < row.count; k++)
                begin
                    r.index  = 5'(k);
                    r.value  = frame_vals[k];
                    r.count  = row.count[5:0];
                    r.crc_ok = row.crc_good;
                    r.last   = (k == row.count - 1);
                    pending_channels.push_back(r);
                end
            end
        end
        rx_quiet();
        wait_results_drained();

        // random bytes fill up the rest of the byte budget in three stretches
        base = bytes_sent;
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    rx_idle_pct  = 15;
                    res_idle_pct = 70;
                end
                1:
                begin
                    rx_idle_pct  = 70;
                    res_idle_pct = 15;
                end
                default:
                begin
                    rx_idle_pct  = 0;
                    res_idle_pct = 0;
                    // sender keeps pushing while results are held back
                    holds_asked++;
                end
            endcase
            goal = base + (ph + 1) * (ITEM_TARGET - base) / 3;
            while (bytes_sent < goal)
                random_chunk();
            // sender waits for every pending result before the next stretch
            rx_quiet();
            wait_results_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes (%0d past hunting), %0d frames decoded, %0d results checked",
                 bytes_sent, items_counted, frames_decoded, results_seen);
        $display("included header errors, crc failures, start bytes in data and long stalls");
        if (error_count == 0 && pending_channels.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/sumd_pkg.sv
hw/rtl/sumd_if.sv
hw/rtl/sumd_parser.sv
hw/rtl/sumd_desc_fifo.sv
hw/rtl/sumd_emitter.sv
hw/rtl/sumd_frame_decoder.sv
verif/sumd_frame_decoder_tb.sv
